// File: rtl/scaled_frame_clock_with_timers_assert.svh
// Assertion macros for the scaled frame clock.
`ifndef SCALED_FRAME_CLOCK_WITH_TIMERS_ASSERT_SVH
`define SCALED_FRAME_CLOCK_WITH_TIMERS_ASSERT_SVH
`ifndef SYNTHESIS
`define SFC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define SFC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define SFC_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define SFC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// File: rtl/sfc_pkg.sv
// Shared types and constants of the scaled frame clock.
package sfc_pkg;
   localparam logic [15:0] SCALE_ONE = 16'd4096;
   localparam logic [15:0] SCALE_MAX = 16'd40960;
   localparam logic [16:0] DELTA_CAP = 17'd100000;
   localparam logic [31:0] WINDOW_US = 32'd1000000;
   localparam logic [1:0] CSR_TARGET = 2'd0;
   localparam logic [1:0] CSR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_PAUSED = 2'd2;
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SCHED = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_MUL   = 8'b00000010,
      ST_ACC   = 8'b00000100,
      ST_SDIV  = 8'b00001000,
      ST_RDIV  = 8'b00010000,
      ST_SLOTS = 8'b00100000,
      ST_SCHED = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   typedef struct packed {
      logic load;      // capture a new word
      logic mul;       // form scaled delta
      logic acc;       // update total, transition and frame window
      logic sdiv_go;   // start scale divide
      logic sdiv_fin;  // apply scale divide
      logic rdiv_go;   // start rate divide
      logic rdiv_fin;  // apply rate divide
      logic slot_step; // process one slot
      logic sched;     // claim a slot
      logic out_load;  // present result
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic need_sdiv;
      logic need_rdiv;
      logic slot_last;
      logic is_sched;
   } status_type;
endpackage

// File: rtl/scaled_frame_clock_with_timers.sv
// Top level of the scaled frame clock with one-shot delay timers.
//  channel  ports            direction  handshake
//  request  req_*            in         req_valid / req_stall
//  response rsp_*            out        rsp_valid / rsp_stall
//  config   csr_*            in         csr_valid / csr_ready
// A schedule word steps through load, MUL, SCHED and OUT. A tick steps through
// load, MUL, ACC, SDIV, RDIV, one SLOTS step per delay slot and OUT; the scale
// and frame-rate divides run only when needed, on the shared 52-step divider,
// and the scan handles one slot a cycle. Reset is synchronous and clears all
// control state. The result register is held while it is valid and rsp_stall is
// high; a new word enters once the previous result has been loaded into it.
`include "scaled_frame_clock_with_timers_assert.svh"
module scaled_frame_clock_with_timers #(
   parameter int DELAY_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_raw_delta_us,
   input  logic [31:0] req_delay_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_scaled_delta_us,
   output logic [47:0] rsp_total_time_us,
   output logic [15:0] rsp_frame_rate,
   output logic [15:0] rsp_scale_now,
   output logic [15:0] rsp_fired_mask,
   output logic        rsp_accepted,
   output logic [3:0]  rsp_slot_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   sfc_pkg::cmd_type    cmd;
   sfc_pkg::status_type stat;
   logic                sched_quiet;

   assign csr_ready = 1'b1;

   sfc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd)
   );

   sfc_dp #(.DELAY_SLOTS(DELAY_SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_opcode(req_opcode), .req_raw_delta_us(req_raw_delta_us),
      .req_delay_us(req_delay_us), .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .rsp_scaled_delta_us(rsp_scaled_delta_us), .rsp_total_time_us(rsp_total_time_us),
      .rsp_frame_rate(rsp_frame_rate), .rsp_scale_now(rsp_scale_now),
      .rsp_fired_mask(rsp_fired_mask), .rsp_accepted(rsp_accepted),
      .rsp_slot_index(rsp_slot_index)
   );

   assign sched_quiet = (rsp_fired_mask == 16'd0) && (rsp_scaled_delta_us == 17'd0);

   `SFC_ASSERT_IMPLY(a_sched_quiet, clock, reset, rsp_valid && rsp_accepted, sched_quiet)
   `SFC_ASSERT_IMPLY(a_scale_range, clock, reset, rsp_valid, rsp_scale_now <= 16'd40960)
   `SFC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
endmodule

// File: rtl/sfc_ctrl.sv
// Sequencer of the scaled frame clock.
module sfc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sfc_pkg::status_type  stat,
   output sfc_pkg::cmd_type     cmd
);
   sfc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic div_wait_ff, div_wait_in;

   assign rsp_valid = rsp_valid_ff;
   // Requests stall outside the idle state; the result register frees when it is empty or being taken.
   assign req_stall = !(state_ff == sfc_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_wait_in = div_wait_ff;
      cmd = '0;
      unique case (state_ff)
         sfc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sfc_pkg::ST_MUL;
            end
         end
         sfc_pkg::ST_MUL: begin
            if (stat.is_sched) begin
               state_in = sfc_pkg::ST_SCHED;
            end else begin
               cmd.mul = 1'b1;
               state_in = sfc_pkg::ST_ACC;
            end
         end
         sfc_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            div_wait_in = 1'b0;
            state_in = sfc_pkg::ST_SDIV;
         end
         sfc_pkg::ST_SDIV: begin
            if (!stat.need_sdiv) begin
               state_in = sfc_pkg::ST_RDIV;
            end else if (!div_wait_ff) begin
               cmd.sdiv_go = 1'b1;
               div_wait_in = 1'b1;
            end else if (!stat.div_busy) begin
               cmd.sdiv_fin = 1'b1;
               div_wait_in = 1'b0;
               state_in = sfc_pkg::ST_RDIV;
            end
         end
         sfc_pkg::ST_RDIV: begin
            if (!stat.need_rdiv) begin
               state_in = sfc_pkg::ST_SLOTS;
            end else if (!div_wait_ff) begin
               cmd.rdiv_go = 1'b1;
               div_wait_in = 1'b1;
            end else if (!stat.div_busy) begin
               cmd.rdiv_fin = 1'b1;
               div_wait_in = 1'b0;
               state_in = sfc_pkg::ST_SLOTS;
            end
         end
         sfc_pkg::ST_SLOTS: begin
            cmd.slot_step = 1'b1;
            if (stat.slot_last) state_in = sfc_pkg::ST_OUT;
         end
         sfc_pkg::ST_SCHED: begin
            cmd.sched = 1'b1;
            state_in = sfc_pkg::ST_OUT;
         end
         sfc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = sfc_pkg::ST_IDLE;
            end
         end
         default: state_in = sfc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_wait_ff <= div_wait_in;
      end
   end
endmodule

// File: rtl/sfc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module sfc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [51:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [51:0] quotient
);
   logic [51:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   assign busy = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[31:0], quo_ff[51]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 6'd52;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[50:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[50:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

// File: rtl/sfc_dp.sv
// Datapath of the scaled frame clock: registers, slots and arithmetic.
module sfc_dp #(
   parameter int DELAY_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  sfc_pkg::cmd_type    cmd,
   output sfc_pkg::status_type stat,
   input  logic                req_opcode,
   input  logic [31:0]         req_raw_delta_us,
   input  logic [31:0]         req_delay_us,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic [16:0]         rsp_scaled_delta_us,
   output logic [47:0]         rsp_total_time_us,
   output logic [15:0]         rsp_frame_rate,
   output logic [15:0]         rsp_scale_now,
   output logic [15:0]         rsp_fired_mask,
   output logic                rsp_accepted,
   output logic [3:0]          rsp_slot_index
);
   localparam int SW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;

   logic [15:0] target_ff, target_in;
   logic [31:0] length_ff, length_in;
   logic        paused_ff, paused_in;
   logic [15:0] scale_ff, scale_in;
   logic        tr_act_ff, tr_act_in;
   logic [31:0] tr_el_ff, tr_el_in;
   logic [47:0] total_ff, total_in;
   logic [15:0] fcnt_ff, fcnt_in;
   logic [31:0] win_ff, win_in;
   logic [15:0] rate_ff, rate_in;
   logic [DELAY_SLOTS-1:0] busy_ff, busy_in;
   logic [31:0] sdelay_ff [DELAY_SLOTS];
   logic [31:0] sel_ff [DELAY_SLOTS];
   logic        op_ff;
   logic [31:0] raw_ff, delay_ff;
   logic [16:0] scaled_ff, scaled_in;
   logic [15:0] fired_ff, fired_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic        sdir_ff, sdir_in;
   logic        need_s_ff, need_s_in, need_r_ff, need_r_in;
   logic [16:0] o_scaled_ff;
   logic [47:0] o_total_ff;
   logic [15:0] o_rate_ff, o_scale_ff, o_fired_ff;
   logic        o_acc_ff, acc_ff, acc_in;
   logic [3:0]  o_slot_ff, slot_ff, slot_in;

   logic [47:0] prod;
   logic [32:0] sum_el, sum_win, sum_slot;
   logic [48:0] sum_tot;
   logic [31:0] el_sat, win_sat, slot_sat;
   logic [15:0] diff;
   logic [47:0] mprod;
   logic        dstart, dbusy;
   logic [51:0] dividend, quo;
   logic [31:0] divisor;
   logic [15:0] cw;
   logic        found;
   logic [SW-1:0] free_idx;

   sfc_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dividend),
      .divisor(divisor), .busy(dbusy), .quotient(quo)
   );

   assign prod = raw_ff * {16'd0, scale_ff};
   assign diff = sdir_ff ? (target_ff - scale_ff) : (scale_ff - target_ff);
   assign mprod = {16'd0, diff} * {16'd0, tr_el_ff};
   assign dstart = cmd.sdiv_go || cmd.rdiv_go;
   assign dividend = cmd.sdiv_go ? {4'd0, mprod}
                                 : ({36'd0, fcnt_ff} * 52'd1000000);
   assign divisor = cmd.sdiv_go ? length_ff : win_ff;
   assign sum_el = {1'b0, tr_el_ff} + {16'd0, scaled_ff};
   assign el_sat = sum_el[32] ? 32'hFFFFFFFF : sum_el[31:0];
   assign sum_win = {1'b0, win_ff} + {16'd0, scaled_ff};
   assign win_sat = sum_win[32] ? 32'hFFFFFFFF : sum_win[31:0];
   assign sum_tot = {1'b0, total_ff} + {32'd0, scaled_ff};
   assign sum_slot = {1'b0, sel_ff[idx_ff]} + {16'd0, scaled_ff};
   assign slot_sat = sum_slot[32] ? 32'hFFFFFFFF : sum_slot[31:0];
   assign cw = (csr_data[15:0] > sfc_pkg::SCALE_MAX) ? sfc_pkg::SCALE_MAX
                                                     : csr_data[15:0];

   always_comb begin
      found = 1'b0;
      free_idx = '0;
      for (int i = DELAY_SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            found = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   assign stat.div_busy = dbusy;
   assign stat.need_sdiv = need_s_ff;
   assign stat.need_rdiv = need_r_ff;
   assign stat.slot_last = (idx_ff == SW'(DELAY_SLOTS - 1));
   assign stat.is_sched = (op_ff == sfc_pkg::OP_SCHED);

   always_comb begin
      target_in = target_ff; length_in = length_ff; paused_in = paused_ff;
      scale_in = scale_ff; tr_act_in = tr_act_ff; tr_el_in = tr_el_ff;
      total_in = total_ff; fcnt_in = fcnt_ff; win_in = win_ff; rate_in = rate_ff;
      busy_in = busy_ff; scaled_in = scaled_ff; fired_in = fired_ff;
      idx_in = idx_ff; sdir_in = sdir_ff; need_s_in = need_s_ff;
      need_r_in = need_r_ff; acc_in = acc_ff; slot_in = slot_ff;
      if (csr_write) begin
         unique case (csr_index)
            sfc_pkg::CSR_TARGET: begin
               target_in = cw; tr_el_in = '0; tr_act_in = (length_ff != 0);
            end
            sfc_pkg::CSR_LENGTH: begin
               length_in = csr_data; tr_el_in = '0; tr_act_in = (csr_data != 0);
            end
            sfc_pkg::CSR_PAUSED: paused_in = csr_data[0];
            default: ;
         endcase
      end
      if (cmd.load) begin
         scaled_in = '0; fired_in = '0; idx_in = '0;
         need_s_in = 1'b0; need_r_in = 1'b0; acc_in = 1'b0; slot_in = '0;
      end
      if (cmd.mul && !paused_ff) begin
         scaled_in = (prod[47:12] > {19'd0, sfc_pkg::DELTA_CAP})
                     ? sfc_pkg::DELTA_CAP : prod[28:12];
      end
      if (cmd.acc) begin
         total_in = sum_tot[48] ? 48'hFFFFFFFFFFFF : sum_tot[47:0];
         if (!tr_act_ff || length_ff == 0) begin
            scale_in = target_ff; tr_act_in = 1'b0;
         end else if (el_sat >= length_ff) begin
            scale_in = target_ff; tr_act_in = 1'b0; tr_el_in = '0;
         end else begin
            tr_el_in = el_sat; need_s_in = 1'b1;
            sdir_in = (target_ff >= scale_ff);
         end
         if (fcnt_ff != 16'hFFFF) fcnt_in = fcnt_ff + 16'd1;
         win_in = win_sat;
         need_r_in = (win_sat >= sfc_pkg::WINDOW_US);
      end
      if (cmd.sdiv_fin) begin
         scale_in = sdir_ff ? scale_ff + quo[15:0] : scale_ff - quo[15:0];
      end
      if (cmd.rdiv_fin) begin
         rate_in = (quo[51:16] != 0) ? 16'hFFFF : quo[15:0];
         fcnt_in = '0; win_in = '0;
      end
      if (cmd.slot_step) begin
         if (busy_ff[idx_ff] && slot_sat >= sdelay_ff[idx_ff]) begin
            busy_in[idx_ff] = 1'b0;
            if (32'(idx_ff) < 16) fired_in[4'(idx_ff)] = 1'b1;
         end
         idx_in = idx_ff + SW'(1);
      end
      if (cmd.sched && found) begin
         busy_in[free_idx] = 1'b1;
         acc_in = 1'b1;
         slot_in = 4'(free_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= sfc_pkg::SCALE_ONE; length_ff <= '0; paused_ff <= 1'b0;
         scale_ff <= sfc_pkg::SCALE_ONE; tr_act_ff <= 1'b0; tr_el_ff <= '0;
         total_ff <= '0; fcnt_ff <= '0; win_ff <= '0; rate_ff <= 16'd60;
         busy_ff <= '0; idx_ff <= '0; need_s_ff <= 1'b0; need_r_ff <= 1'b0;
      end else begin
         target_ff <= target_in; length_ff <= length_in; paused_ff <= paused_in;
         scale_ff <= scale_in; tr_act_ff <= tr_act_in; tr_el_ff <= tr_el_in;
         total_ff <= total_in; fcnt_ff <= fcnt_in; win_ff <= win_in;
         rate_ff <= rate_in; busy_ff <= busy_in; idx_ff <= idx_in;
         need_s_ff <= need_s_in; need_r_ff <= need_r_in;
      end
      scaled_ff <= scaled_in; fired_ff <= fired_in; sdir_ff <= sdir_in;
      acc_ff <= acc_in; slot_ff <= slot_in;
      if (cmd.load) begin
         op_ff <= req_opcode; raw_ff <= req_raw_delta_us; delay_ff <= req_delay_us;
      end
      if (cmd.slot_step) sel_ff[idx_ff] <= slot_sat;
      if (cmd.sched && found) begin
         sdelay_ff[free_idx] <= delay_ff;
         sel_ff[free_idx] <= '0;
      end
      if (cmd.out_load) begin
         o_scaled_ff <= scaled_ff; o_total_ff <= total_ff; o_rate_ff <= rate_ff;
         o_scale_ff <= scale_ff; o_fired_ff <= fired_ff; o_acc_ff <= acc_ff;
         o_slot_ff <= slot_ff;
      end
   end

   assign rsp_scaled_delta_us = o_scaled_ff;
   assign rsp_total_time_us = o_total_ff;
   assign rsp_frame_rate = o_rate_ff;
   assign rsp_scale_now = o_scale_ff;
   assign rsp_fired_mask = o_fired_ff;
   assign rsp_accepted = o_acc_ff;
   assign rsp_slot_index = o_slot_ff;
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the scaled frame clock with one-shot delay timers.
module tb;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_WORDS = 135;

   typedef struct packed {
      logic [16:0] scaled;
      logic [47:0] total;
      logic [15:0] rate;
      logic [15:0] scale;
      logic [15:0] fired;
      logic        taken;
      logic [3:0]  slot;
   } clock_result_type;

   typedef struct {
      logic             op;
      logic [31:0]      raw;
      logic [31:0]      dly;
      bit               known;
      clock_result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = sfc_pkg::OP_TICK;
   logic [31:0] req_raw_delta_us = '0;
   logic [31:0] req_delay_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_scaled_delta_us;
   logic [47:0] rsp_total_time_us;
   logic [15:0] rsp_frame_rate;
   logic [15:0] rsp_scale_now;
   logic [15:0] rsp_fired_mask;
   logic        rsp_accepted;
   logic [3:0]  rsp_slot_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   scaled_frame_clock_with_timers u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted configuration and state of the clock.
   logic [15:0] cfg_target;
   logic [31:0] cfg_length;
   logic        cfg_paused;
   logic [15:0] scale_cur;
   logic        ramp_on;
   logic [31:0] ramp_elapsed;
   logic [47:0] total_us;
   logic [15:0] frame_cnt;
   logic [31:0] window_us;
   logic [15:0] rate_fps;
   logic        slot_busy [16];
   logic [31:0] slot_delay [16];
   logic [31:0] slot_elapsed [16];

   clock_result_type expected_q [$];
   stim_row_type     dir_rows [$];
   int  err_cnt = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;
   bit  hold_req = 0;

   function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic clock_result_type advance_clock(logic op, logic [31:0] raw,
                                                      logic [31:0] dly);
      clock_result_type r;
      logic [63:0] prod;
      logic [63:0] mag;
      logic [48:0] tsum;
      logic [31:0] scaled;
      r = '0;
      if (op == sfc_pkg::OP_TICK) begin
         scaled = '0;
         if (!cfg_paused) begin
            prod = ({32'b0, raw} * {48'b0, scale_cur}) >> 12;
            scaled = (prod > 64'd100000) ? 32'd100000 : prod[31:0];
         end
         tsum = {1'b0, total_us} + {17'b0, scaled};
         total_us = tsum[48] ? 48'hFFFF_FFFF_FFFF : tsum[47:0];
         if (!ramp_on || cfg_length == 0) begin
            scale_cur = cfg_target;
            ramp_on = 1'b0;
         end else begin
            ramp_elapsed = add_sat32(ramp_elapsed, scaled);
            if (ramp_elapsed >= cfg_length) begin
               scale_cur = cfg_target;
               ramp_on = 1'b0;
               ramp_elapsed = '0;
            end else if (cfg_target >= scale_cur) begin
               mag = (64'(cfg_target - scale_cur) * 64'(ramp_elapsed)) / 64'(cfg_length);
               scale_cur = scale_cur + mag[15:0];
            end else begin
               mag = (64'(scale_cur - cfg_target) * 64'(ramp_elapsed)) / 64'(cfg_length);
               scale_cur = scale_cur - mag[15:0];
            end
         end
         if (frame_cnt != 16'hFFFF) frame_cnt = frame_cnt + 1'b1;
         window_us = add_sat32(window_us, scaled);
         if (window_us >= 32'd1000000) begin
            mag = (64'(frame_cnt) * 64'd1000000) / 64'(window_us);
            rate_fps = (mag > 64'hFFFF) ? 16'hFFFF : mag[15:0];
            frame_cnt = '0;
            window_us = '0;
         end
         for (int i = 0; i < 16; i++) begin
            if (slot_busy[i]) begin
               slot_elapsed[i] = add_sat32(slot_elapsed[i], scaled);
               if (slot_elapsed[i] >= slot_delay[i]) begin
                  slot_busy[i] = 1'b0;
                  r.fired[i] = 1'b1;
               end
            end
         end
         r.scaled = scaled[16:0];
      end else begin
         for (int i = 0; i < 16; i++) begin
            if (!slot_busy[i] && !r.taken) begin
               slot_busy[i] = 1'b1;
               slot_delay[i] = dly;
               slot_elapsed[i] = '0;
               r.taken = 1'b1;
               r.slot = i[3:0];
            end
         end
      end
      r.total = total_us;
      r.rate = rate_fps;
      r.scale = scale_cur;
      return r;
   endfunction

   task automatic add_row(logic op, logic [31:0] raw, logic [31:0] dly);
      stim_row_type row;
      row.op = op;
      row.raw = raw;
      row.dly = dly;
      row.known = 0;
      row.res = '0;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic add_known(logic op, logic [31:0] raw, logic [31:0] dly, logic [16:0] sd,
                            logic [47:0] tot, logic taken, logic [3:0] slot);
      stim_row_type row;
      row.op = op;
      row.raw = raw;
      row.dly = dly;
      row.known = 1;
      row.res = '{sd, tot, 16'd60, sfc_pkg::SCALE_ONE, 16'd0, taken, slot};
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // Drives one word and holds it until the block takes it.
   task automatic send_word(logic op, logic [31:0] raw, logic [31:0] dly, bit known,
                            clock_result_type typed);
      clock_result_type pred;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_raw_delta_us <= raw;
      req_delay_us <= dly;
      do @(posedge clock); while (req_stall);
      pred = advance_clock(op, raw, dly);
      expected_q.insert(expected_q.size(), known ? typed : pred);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic        op;
      logic [31:0] raw;
      logic [31:0] dly;
      op = ($urandom_range(0, 2) == 0) ? sfc_pkg::OP_SCHED : sfc_pkg::OP_TICK;
      case ($urandom_range(0, 9))
         0: raw = '0;
         1: raw = $urandom;
         default: raw = $urandom_range(0, 60000);
      endcase
      case ($urandom_range(0, 7))
         0: dly = '0;
         1: dly = $urandom;
         default: dly = $urandom_range(0, 400000);
      endcase
      send_word(op, raw, dly, 0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sfc_pkg::CSR_TARGET: begin
            cfg_target = (data[15:0] > sfc_pkg::SCALE_MAX) ? sfc_pkg::SCALE_MAX : data[15:0];
            ramp_elapsed = '0;
            ramp_on = (cfg_length != 0);
         end
         sfc_pkg::CSR_LENGTH: begin
            cfg_length = data;
            ramp_elapsed = '0;
            ramp_on = (cfg_length != 0);
         end
         sfc_pkg::CSR_PAUSED: cfg_paused = data[0];
         default: ;
      endcase
   endtask

   task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      clock_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            err_cnt++;
         end else begin
            e = expected_q.pop_front();
            report("scaled_delta_us", 64'(e.scaled), 64'(rsp_scaled_delta_us));
            report("total_time_us", 64'(e.total), 64'(rsp_total_time_us));
            report("frame_rate", 64'(e.rate), 64'(rsp_frame_rate));
            report("scale_now", 64'(e.scale), 64'(rsp_scale_now));
            report("fired_mask", 64'(e.fired), 64'(rsp_fired_mask));
            report("accepted", 64'(e.taken), 64'(rsp_accepted));
            report("slot_index", 64'(e.slot), 64'(rsp_slot_index));
         end
      end
   end

   // Receiver back-pressure: random bursts, one long hold when asked, none at the end.
   initial begin
      int n;
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      logic [15:0] targets [8];
      logic [31:0] lengths [8];
      logic        pauses [8];
      targets = '{16'd4096, 16'd40960, 16'd0, 16'hFFFF,
                  16'd8192, 16'd2048, 16'd4096, 16'd20000};
      lengths = '{32'd0, 32'd500000, 32'd200000, 32'd0,
                  32'hFFFF_FFFF, 32'd1000, 32'd300000, 32'd0};
      pauses = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      cfg_target = sfc_pkg::SCALE_ONE;
      cfg_length = '0;
      cfg_paused = 1'b0;
      scale_cur = sfc_pkg::SCALE_ONE;
      ramp_on = 1'b0;
      ramp_elapsed = '0;
      total_us = '0;
      frame_cnt = '0;
      window_us = '0;
      rate_fps = 16'd60;
      for (int i = 0; i < 16; i++) begin
         slot_busy[i] = 1'b0;
         slot_delay[i] = '0;
         slot_elapsed[i] = '0;
      end

      add_known(sfc_pkg::OP_TICK, 32'd0, 32'hFFFF_FFFF, 17'd0, 48'd0, 1'b0, 4'd0);
      add_known(sfc_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 17'd100000, 48'd100000,
                1'b0, 4'd0);
      add_known(sfc_pkg::OP_SCHED, 32'hFFFF_FFFF, 32'd0, 17'd0, 48'd100000, 1'b1, 4'd0);
      add_known(sfc_pkg::OP_SCHED, 32'd0, 32'hFFFF_FFFF, 17'd0, 48'd100000, 1'b1, 4'd1);
      for (int i = 2; i < 16; i++) add_row(sfc_pkg::OP_SCHED, 32'h5555_5555, i * 50000);
      // Every slot is taken now, so this one is turned away.
      add_known(sfc_pkg::OP_SCHED, 32'hAAAA_AAAA, 32'd5, 17'd0, 48'd100000, 1'b0, 4'd0);
      add_row(sfc_pkg::OP_TICK, 32'd1, 32'hAAAA_AAAA);
      add_row(sfc_pkg::OP_TICK, 32'd150000, 32'd0);
      add_row(sfc_pkg::OP_SCHED, 32'd0, 32'd1);
      add_row(sfc_pkg::OP_TICK, 32'd0, 32'd0);
      add_row(sfc_pkg::OP_TICK, 32'd100000, 32'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_word(dir_rows[i].op, dir_rows[i].raw, dir_rows[i].dly, dir_rows[i].known,
                   dir_rows[i].res);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         // The upper half of the target word is ignored by the block.
         write_reg(sfc_pkg::CSR_TARGET, {16'($urandom), targets[ph]});
         write_reg(sfc_pkg::CSR_LENGTH, lengths[ph]);
         write_reg(sfc_pkg::CSR_PAUSED, {31'b0, pauses[ph]});
         if (ph == 6) write_reg(CSR_UNUSED, $urandom);
         csr_valid <= 1'b0;
         if (ph == 7) quiet = 1;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (ph == 1 && k == 10) hold_req = 1;
            if (ph == 3 && k == 60) drain();
            send_random();
         end
      end
      drain();
      repeat (200) @(posedge clock);
      if (err_cnt == 0 && expected_q.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/sfc_pkg.sv
rtl/sfc_ctrl.sv
rtl/sfc_div.sv
rtl/sfc_dp.sv
rtl/scaled_frame_clock_with_timers.sv
tb/sv/tb.sv
